/* rtl/core/sprite_alpha_blend_overlay_assert.svh */
`ifndef SPRITE_ALPHA_BLEND_OVERLAY_ASSERT_SVH
`define SPRITE_ALPHA_BLEND_OVERLAY_ASSERT_SVH

// same-cycle implication
`define SABO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SABO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sabo_pkg.sv */
package sabo_pkg;

  localparam int MAX_SPRITE_SIDE = 64;
  localparam int MAX_FRAME_SIDE  = 2048;

  localparam int SIDE_W      = $clog2(MAX_SPRITE_SIDE);
  localparam int STORE_DEPTH = MAX_SPRITE_SIDE * MAX_SPRITE_SIDE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int FRAME_DIM_W  = 12;
  localparam int SPRITE_DIM_W = 7;
  localparam int POS_W        = 11;
  localparam int ADDR_W       = 12;
  localparam int WORD_W       = 32;
  localparam int RGB_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  localparam logic [FRAME_DIM_W-1:0]  FRAME_SIDE_MAX  = FRAME_DIM_W'(MAX_FRAME_SIDE);
  localparam logic [SPRITE_DIM_W-1:0] SPRITE_SIDE_MAX = SPRITE_DIM_W'(MAX_SPRITE_SIDE);

  // round(n / 255) as ((n + 127) * 32897) >> 23, exact for n below 2^16
  localparam logic [15:0] BLEND_ROUND = 16'd127;
  localparam logic [15:0] BLEND_RECIP = 16'd32897;
  localparam int          BLEND_SHIFT = 23;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_SPRITE_X      = 3'd2,
    CFG_SPRITE_Y      = 3'd3,
    CFG_SPRITE_WIDTH  = 3'd4,
    CFG_SPRITE_HEIGHT = 3'd5,
    CFG_FLIP_ROWS     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAME_DIM_W-1:0]         frame_width;
    logic [FRAME_DIM_W-1:0]         frame_height;
    logic signed [FRAME_DIM_W-1:0]  sprite_x;
    logic signed [FRAME_DIM_W-1:0]  sprite_y;
    logic [SPRITE_DIM_W-1:0]        sprite_width;
    logic [SPRITE_DIM_W-1:0]        sprite_height;
    logic                           flip_rows;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   sprite_address;
    logic [WORD_W-1:0]   sprite_word;
    logic [POS_W-1:0]    column;
    logic [POS_W-1:0]    line;
    logic [RGB_W-1:0]    frame_pixel;
  } pix_t;

  // store access stage
  typedef struct packed {
    logic                     valid;
    logic                     is_pixel;
    logic                     hit;
    logic [SIDE_W-1:0]        row;
    logic [SIDE_W-1:0]        col;
    logic [SPRITE_DIM_W-1:0]  stride;
    logic [ADDR_W-1:0]        load_addr;
    logic [WORD_W-1:0]        word;
    logic [RGB_W-1:0]         dst;
  } acc_t;

  // blend stage input
  typedef struct packed {
    logic              valid;
    logic              is_pixel;
    logic              hit;
    logic [RGB_W-1:0]  dst;
  } mix_t;

endpackage

/* rtl/core/sabo_pix_if.sv */
interface sabo_pix_if;
  import sabo_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [ADDR_W-1:0]   sprite_address;
  logic [WORD_W-1:0]   sprite_word;
  logic [POS_W-1:0]    column;
  logic [POS_W-1:0]    line;
  logic [RGB_W-1:0]    frame_pixel;

  modport source (
    output valid, kind, sprite_address, sprite_word, column, line, frame_pixel,
    input  ready
  );

  modport sink (
    input  valid, kind, sprite_address, sprite_word, column, line, frame_pixel,
    output ready
  );
endinterface

/* rtl/core/sabo_res_if.sv */
interface sabo_res_if;
  import sabo_pkg::*;

  logic              valid;
  logic              ready;
  logic [RGB_W-1:0]  pixel_out;
  logic              covered;

  modport source (
    output valid, pixel_out, covered,
    input  ready
  );

  modport sink (
    input  valid, pixel_out, covered,
    output ready
  );
endinterface

/* rtl/core/sabo_cfg_if.sv */
interface sabo_cfg_if;
  import sabo_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* rtl/core/sabo_ram.sv */
module sabo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sabo_clip.sv */
module sabo_clip (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  sabo_pkg::pix_t pix_i,
  input  sabo_pkg::cfg_t cfg_i,
  output sabo_pkg::acc_t acc_o
);
  import sabo_pkg::*;

  typedef struct packed {
    logic                     valid;
    logic                     is_pixel;
    logic                     in_frame;
    logic signed [FRAME_DIM_W:0] sc;
    logic signed [FRAME_DIM_W:0] sr;
    logic [ADDR_W-1:0]        load_addr;
    logic [WORD_W-1:0]        word;
    logic [RGB_W-1:0]         dst;
  } pos_t;

  logic [FRAME_DIM_W-1:0]  fw_c, fh_c;
  logic [SPRITE_DIM_W-1:0] sw_c, sh_c;
  pos_t                    pos_d, pos_q;
  acc_t                    acc_d, acc_q;
  logic                    sc_in, sr_in;
  logic [SPRITE_DIM_W-1:0] flip_row;

  // clamp oversized dimensions
  assign fw_c = (cfg_i.frame_width > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : cfg_i.frame_width;
  assign fh_c = (cfg_i.frame_height > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : cfg_i.frame_height;
  assign sw_c = (cfg_i.sprite_width > SPRITE_SIDE_MAX) ? SPRITE_SIDE_MAX : cfg_i.sprite_width;
  assign sh_c = (cfg_i.sprite_height > SPRITE_SIDE_MAX) ? SPRITE_SIDE_MAX
                                                         : cfg_i.sprite_height;

  // position relative to sprite origin
  always_comb begin
    pos_d.valid     = valid_i;
    pos_d.is_pixel  = (pix_i.kind == KIND_PIXEL);
    pos_d.in_frame  = ({1'b0, pix_i.column} < fw_c) && ({1'b0, pix_i.line} < fh_c);
    pos_d.sc        = $signed({2'b00, pix_i.column}) -
                      $signed({cfg_i.sprite_x[FRAME_DIM_W-1], cfg_i.sprite_x});
    pos_d.sr        = $signed({2'b00, pix_i.line}) -
                      $signed({cfg_i.sprite_y[FRAME_DIM_W-1], cfg_i.sprite_y});
    pos_d.load_addr = pix_i.sprite_address;
    pos_d.word      = pix_i.sprite_word;
    pos_d.dst       = pix_i.frame_pixel;
  end

  // rectangle test and row flip
  always_comb begin
    sc_in = !pos_q.sc[FRAME_DIM_W] &&
            (pos_q.sc[FRAME_DIM_W-1:0] < {{(FRAME_DIM_W-SPRITE_DIM_W){1'b0}}, sw_c});
    sr_in = !pos_q.sr[FRAME_DIM_W] &&
            (pos_q.sr[FRAME_DIM_W-1:0] < {{(FRAME_DIM_W-SPRITE_DIM_W){1'b0}}, sh_c});
    flip_row = SPRITE_DIM_W'(sh_c - SPRITE_DIM_W'(1) -
                             {1'b0, pos_q.sr[SIDE_W-1:0]});

    acc_d.valid     = pos_q.valid;
    acc_d.is_pixel  = pos_q.is_pixel;
    acc_d.hit       = pos_q.is_pixel && pos_q.in_frame && sc_in && sr_in;
    acc_d.row       = cfg_i.flip_rows ? flip_row[SIDE_W-1:0] : pos_q.sr[SIDE_W-1:0];
    acc_d.col       = pos_q.sc[SIDE_W-1:0];
    acc_d.stride    = sw_c;
    acc_d.load_addr = pos_q.load_addr;
    acc_d.word      = pos_q.word;
    acc_d.dst       = pos_q.dst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q.valid <= 1'b0;
      acc_q.valid <= 1'b0;
    end else if (adv_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* rtl/core/sabo_blend.sv */
module sabo_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  sabo_pkg::mix_t                  mix_i,
  input  logic [sabo_pkg::WORD_W-1:0]     src_i,
  output logic                            valid_o,
  output logic [sabo_pkg::RGB_W-1:0]      pixel_out_o,
  output logic                            covered_o
);
  import sabo_pkg::*;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [RGB_W-1:0]  dst;
    logic [2:0][15:0]  num;
  } sum_t;

  sum_t              sum_d, sum_q;
  logic [7:0]        alpha, inv_alpha;
  logic [2:0][15:0]  dst_part, src_part;
  logic [2:0][31:0]  scaled;
  logic [RGB_W-1:0]  mixed;
  logic              out_valid_q;
  logic [RGB_W-1:0]  pixel_out_q;
  logic              covered_q;

  // weighted sum per channel
  always_comb begin
    alpha     = src_i[31:24];
    inv_alpha = 8'hFF - alpha;
    for (int ch = 0; ch < 3; ch++) begin
      dst_part[ch]   = {8'h00, mix_i.dst[8*ch +: 8]} * {8'h00, inv_alpha};
      src_part[ch]   = {8'h00, src_i[8*ch +: 8]} * {8'h00, alpha};
      sum_d.num[ch]  = dst_part[ch] + src_part[ch] + BLEND_ROUND;
    end
    sum_d.valid = mix_i.valid && mix_i.is_pixel;
    sum_d.hit   = mix_i.hit;
    sum_d.dst   = mix_i.dst;
  end

  // divide by 255 through the reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      scaled[ch]          = {16'h0000, sum_q.num[ch]} * {16'h0000, BLEND_RECIP};
      mixed[8*ch +: 8]    = scaled[ch][BLEND_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q.valid <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      sum_q       <= sum_d;
      out_valid_q <= sum_q.valid;
      pixel_out_q <= sum_q.hit ? mixed : sum_q.dst;
      covered_q   <= sum_q.hit;
    end
  end

  assign valid_o     = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign covered_o   = covered_q;

endmodule

/* rtl/core/sprite_alpha_blend_overlay.sv */
// a result word passes the pos, acc, mix, sum and output registers after its input word is accepted
// throughput: one word per cycle unless the result side stalls, loads and pixels alike; loads give no result
// a stall on the result side freezes every stage and holds off the input
// reset: clears all stage valid bits and the configuration registers to their defaults
// the sprite store is not cleared; entries are defined once loaded
module sprite_alpha_blend_overlay (
  input  logic  clk_i,
  input  logic  rst_ni,
  sabo_pix_if.sink   pix_i,
  sabo_res_if.source pix_o,
  sabo_cfg_if.sink   cfg_i
);
  import sabo_pkg::*;

  `include "sprite_alpha_blend_overlay_assert.svh"

  cfg_t                 cfg_q;
  pix_t                 pix;
  logic                 adv;
  acc_t                 acc;
  mix_t                 mix_d, mix_q;
  logic [STORE_AW-1:0]  ram_addr;
  logic [12:0]          row_base;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_rdata;
  logic                 res_valid;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_SIDE_MAX;
      cfg_q.frame_height  <= FRAME_SIDE_MAX;
      cfg_q.sprite_x      <= '0;
      cfg_q.sprite_y      <= '0;
      cfg_q.sprite_width  <= SPRITE_SIDE_MAX;
      cfg_q.sprite_height <= SPRITE_SIDE_MAX;
      cfg_q.flip_rows     <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_i.data;
        CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_i.data;
        CFG_SPRITE_X:      cfg_q.sprite_x      <= $signed(cfg_i.data);
        CFG_SPRITE_Y:      cfg_q.sprite_y      <= $signed(cfg_i.data);
        CFG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_i.data[SPRITE_DIM_W-1:0];
        CFG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_i.data[SPRITE_DIM_W-1:0];
        CFG_FLIP_ROWS:     cfg_q.flip_rows     <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // whole pipe moves unless a result word is stuck
  assign adv         = !res_valid || pix_o.ready;
  assign pix_i.ready = adv;

  always_comb begin
    pix.kind           = pix_i.kind;
    pix.sprite_address = pix_i.sprite_address;
    pix.sprite_word    = pix_i.sprite_word;
    pix.column         = pix_i.column;
    pix.line           = pix_i.line;
    pix.frame_pixel    = pix_i.frame_pixel;
  end

  sabo_clip u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(pix_i.valid),
    .pix_i  (pix),
    .cfg_i  (cfg_q),
    .acc_o  (acc)
  );

  // store access: loads write, pixels read
  assign row_base = {7'b0, acc.row} * {6'b0, acc.stride};
  assign ram_addr = acc.is_pixel ? STORE_AW'(row_base + 13'(acc.col))
                                 : acc.load_addr[STORE_AW-1:0];
  assign ram_we   = adv && acc.valid && !acc.is_pixel;

  sabo_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (adv),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(acc.word),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    mix_d.valid    = acc.valid;
    mix_d.is_pixel = acc.is_pixel;
    mix_d.hit      = acc.hit;
    mix_d.dst      = acc.dst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q.valid <= 1'b0;
    end else if (adv) begin
      mix_q <= mix_d;
    end
  end

  sabo_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .mix_i      (mix_q),
    .src_i      (ram_rdata),
    .valid_o    (res_valid),
    .pixel_out_o(pix_o.pixel_out),
    .covered_o  (pix_o.covered)
  );

  assign pix_o.valid = res_valid;

  `SABO_ASSERT_NOW(a_stall_blocks_input, clk_i, rst_ni, pix_o.valid && !pix_o.ready, !pix_i.ready, "input taken while result stalled")
  `SABO_ASSERT_NOW(a_hit_only_pixel, clk_i, rst_ni, mix_q.valid && mix_q.hit, mix_q.is_pixel, "load word marked as covered")
  `SABO_ASSERT_NEXT(a_no_write_on_stall, clk_i, rst_ni, !adv && mix_q.valid, mix_q.valid, "stage word lost during stall")

endmodule
